FILE: rtl/core/bci_pkg.sv
// ----------------------------------------------------------------------------
// bci_pkg: shared types and constants of the breakpoint curve interpolator
// Word layouts, breakpoint entry, table write bundle and code constants.
// ----------------------------------------------------------------------------
package bci_pkg;

    localparam int MAX_BP   = 64;
    localparam int IDX_W    = $clog2(MAX_BP);
    localparam int CNT_W    = 7;
    localparam int POS_W    = 16;
    localparam int VAL_W    = 16;
    localparam int ACC_W    = 68;  // holds dv * S with margin
    localparam int LOC_W    = 28;  // local ratio in Q16, extrapolated range
    localparam int DIV_STEPS = 32;

    localparam logic [CNT_W-1:0] COUNT_RESET = 7'd2;
    localparam logic [CNT_W-1:0] COUNT_MIN   = 7'd2;
    localparam logic [CNT_W-1:0] COUNT_MAX   = 7'd64;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_EVAL  = 1'b1;

    localparam logic [1:0] SHAPE_HERMITE = 2'd1;
    localparam logic [1:0] SHAPE_STEP    = 2'd2;

    localparam logic signed [POS_W:0] SPAN_MIN = 17'sd65;

    localparam logic REG_COUNT = 1'b0;

    typedef struct packed {
        logic                    operation;
        logic [IDX_W-1:0]        entry_index;
        logic [POS_W-1:0]        entry_position;
        logic signed [VAL_W-1:0] entry_value;
        logic [1:0]              entry_shape;
        logic [POS_W-1:0]        phase;
    } t_in_word;

    typedef struct packed {
        logic signed [VAL_W-1:0] curve_value;
        logic [IDX_W-1:0]        segment_index;
    } t_out_word;

    typedef struct packed {
        logic [1:0]              shape;
        logic signed [VAL_W-1:0] value;
        logic [POS_W-1:0]        position;
    } t_entry;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        t_entry           data;
    } t_tbl_wr;

endpackage

FILE: rtl/core/bci_table.sv
// ----------------------------------------------------------------------------
// bci_table: breakpoint table memory
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bci_table (
    input  logic                        i_clk,
    input  bci_pkg::t_tbl_wr            i_wr,
    input  logic [bci_pkg::IDX_W-1:0]   i_rd_addr,
    output bci_pkg::t_entry             o_rd_data
);

    bci_pkg::t_entry mem [bci_pkg::MAX_BP];
    bci_pkg::t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.addr] <= i_wr.data;
        end
        r_rd_data <= mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/core/breakpoint_curve_interpolator.sv
// ----------------------------------------------------------------------------
// breakpoint_curve_interpolator: piecewise breakpoint curve evaluator
// Holds up to 64 breakpoints (position, value, shape). A write word loads one
// entry; an evaluate word returns the step, linear or Hermite value at a phase.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+---------------------------
//  input    | in        | i_in_valid/o_in_ready  | i_in_data  (t_in_word)
//  output   | out       | o_out_valid/i_out_ready| o_out_data (t_out_word)
//  config   | in        | APB psel/penable       | paddr/pwdata/prdata
//
//  A write word leaves the sequencer idle. An evaluate word runs from its
//  accepting edge to o_out_valid: the segment search reads one table entry per
//  cycle, then one shared 68-bit adder does a 32-step restoring divide and
//  shift-add multiplies (16 steps linear; 28+28+16 steps Hermite); a step entry
//  or a span of at most 65 skips both.
//  Reset (synchronous, active low) clears the sequencer, output valid and the
//  count register to 2; the table is not cleared.
//  o_in_ready is high only while the sequencer is idle; a result waiting on
//  i_out_ready holds the sequencer in its last step, an idle one still takes
//  words.
// ----------------------------------------------------------------------------
module breakpoint_curve_interpolator (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  bci_pkg::t_in_word    i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output bci_pkg::t_out_word   o_out_data,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam int ACC_W = bci_pkg::ACC_W;
    localparam int LOC_W = bci_pkg::LOC_W;
    localparam int IDX_W = bci_pkg::IDX_W;
    localparam int POS_W = bci_pkg::POS_W;
    localparam int VAL_W = bci_pkg::VAL_W;

    // sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SRCH  = 4'd1;
    localparam logic [3:0] S_SETUP = 4'd2;
    localparam logic [3:0] S_DIV   = 4'd3;
    localparam logic [3:0] S_LOC   = 4'd4;
    localparam logic [3:0] S_PREP  = 4'd5;
    localparam logic [3:0] S_MUL   = 4'd6;
    localparam logic [3:0] S_NEG   = 4'd7;
    localparam logic [3:0] S_S1    = 4'd8;
    localparam logic [3:0] S_S2    = 4'd9;
    localparam logic [3:0] S_S3    = 4'd10;
    localparam logic [3:0] S_RND   = 4'd11;
    localparam logic [3:0] S_FIN   = 4'd12;

    // which multiply is running
    localparam logic [1:0] M_LIN  = 2'd0;  // dv * local
    localparam logic [1:0] M_SQ   = 2'd1;  // local * local
    localparam logic [1:0] M_CUBE = 2'd2;  // t2 * local
    localparam logic [1:0] M_DVS  = 2'd3;  // dv * S

    localparam logic [4:0] MUL_LOC_LAST = 5'(LOC_W - 1);
    localparam logic [4:0] MUL_DV_LAST  = 5'(VAL_W - 1);
    localparam logic [4:0] DIV_LAST     = 5'(bci_pkg::DIV_STEPS - 1);

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    logic [3:0]                     r_state, n_state;
    logic [bci_pkg::CNT_W-1:0]      r_count, n_count;
    logic [POS_W-1:0]               r_phase, n_phase;
    logic [IDX_W-1:0]               r_last, n_last;
    logic [IDX_W-1:0]               r_addr, n_addr;
    logic                           r_rd_vld, n_rd_vld;
    logic [IDX_W-1:0]               r_didx, n_didx;
    bci_pkg::t_entry                r_first, n_first;
    bci_pkg::t_entry                r_prev, n_prev;
    bci_pkg::t_entry                r_lo, n_lo;
    bci_pkg::t_entry                r_hi, n_hi;
    logic [IDX_W-1:0]               r_seg, n_seg;
    logic [POS_W-1:0]               r_span, n_span;
    logic                           r_dneg, n_dneg;
    logic signed [VAL_W:0]          r_dv, n_dv;
    logic [POS_W-1:0]               r_rem, n_rem;
    logic [bci_pkg::DIV_STEPS-1:0]  r_quo, n_quo;
    logic signed [LOC_W-1:0]        r_local, n_local;
    logic signed [ACC_W-1:0]        r_acc, n_acc;
    logic signed [ACC_W-1:0]        r_mcand, n_mcand;
    logic signed [ACC_W-1:0]        r_t2, n_t2;
    logic [LOC_W-1:0]               r_mplier, n_mplier;
    logic [4:0]                     r_cnt, n_cnt;
    logic                           r_neg, n_neg;
    logic [1:0]                     r_step, n_step;
    bci_pkg::t_out_word             r_out, n_out;
    logic                           r_out_vld, n_out_vld;

    // ------------------------------------------------------------------
    // table
    // ------------------------------------------------------------------
    bci_pkg::t_tbl_wr  tbl_wr;
    bci_pkg::t_entry   rd_data;

    bci_table u_table (
        .i_clk     (i_clk),
        .i_wr      (tbl_wr),
        .i_rd_addr (r_addr),
        .o_rd_data (rd_data)
    );

    logic in_acc;
    assign in_acc = i_in_valid && o_in_ready;

    always_comb begin
        tbl_wr.en              = in_acc && (i_in_data.operation == bci_pkg::OP_WRITE);
        tbl_wr.addr            = i_in_data.entry_index;
        tbl_wr.data.shape      = i_in_data.entry_shape;
        tbl_wr.data.value      = i_in_data.entry_value;
        tbl_wr.data.position   = i_in_data.entry_position;
    end

    // ------------------------------------------------------------------
    // config port
    // ------------------------------------------------------------------
    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[2] == bci_pkg::REG_COUNT);
    assign pready = 1'b1;
    assign prdata = (paddr[2] == bci_pkg::REG_COUNT) ? {25'd0, r_count} : 32'd0;

    // count clamped to 2..64, last index searched as high entry
    logic [bci_pkg::CNT_W-1:0] cnt_c;
    always_comb begin
        if (r_count < bci_pkg::COUNT_MIN) begin
            cnt_c = bci_pkg::COUNT_MIN;
        end else if (r_count > bci_pkg::COUNT_MAX) begin
            cnt_c = bci_pkg::COUNT_MAX;
        end else begin
            cnt_c = r_count;
        end
    end

    // ------------------------------------------------------------------
    // shared adder: the divide, multiply, Hermite and rounding arithmetic goes here
    // ------------------------------------------------------------------
    logic signed [ACC_W-1:0] opa, opb, sum;
    logic                    cin;
    assign sum = opa + opb + ACC_W'(cin);

    // narrow helpers
    logic signed [POS_W:0]  span17, d17, dv17;
    logic [POS_W-1:0]       dmag;
    logic [LOC_W-1:0]       loc_mag;
    logic [VAL_W-1:0]       dv_mag;
    logic                   hit;
    logic signed [VAL_W-1:0] sat;

    assign span17  = $signed({1'b0, r_hi.position}) - $signed({1'b0, r_lo.position});
    assign d17     = $signed({1'b0, r_phase}) - $signed({1'b0, r_lo.position});
    assign dv17    = (VAL_W+1)'(r_hi.value) - (VAL_W+1)'(r_lo.value);
    assign dmag    = d17[POS_W] ? POS_W'(-d17) : d17[POS_W-1:0];
    assign loc_mag = r_local[LOC_W-1] ? LOC_W'(-r_local) : LOC_W'(r_local);
    assign dv_mag  = r_dv[VAL_W] ? VAL_W'(-r_dv) : r_dv[VAL_W-1:0];
    assign hit     = (r_phase >= r_prev.position) && (r_phase < rd_data.position);

    // Q1.15 saturation of the final sum
    always_comb begin
        if (sum > ACC_W'(32767)) begin
            sat = 16'sh7FFF;
        end else if (sum < -ACC_W'(32768)) begin
            sat = -16'sh8000;
        end else begin
            sat = sum[VAL_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_phase   = r_phase;
        n_last    = r_last;
        n_addr    = r_addr;
        n_rd_vld  = 1'b0;
        n_didx    = r_didx;
        n_first   = r_first;
        n_prev    = r_prev;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_seg     = r_seg;
        n_span    = r_span;
        n_dneg    = r_dneg;
        n_dv      = r_dv;
        n_rem     = r_rem;
        n_quo     = r_quo;
        n_local   = r_local;
        n_acc     = r_acc;
        n_mcand   = r_mcand;
        n_t2      = r_t2;
        n_mplier  = r_mplier;
        n_cnt     = r_cnt;
        n_neg     = r_neg;
        n_step    = r_step;
        n_out     = r_out;
        n_out_vld = r_out_vld && !i_out_ready;
        opa       = '0;
        opb       = '0;
        cin       = 1'b0;

        if (cfg_wr) begin
            n_count = pwdata[bci_pkg::CNT_W-1:0];
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc && (i_in_data.operation == bci_pkg::OP_EVAL)) begin
                    n_phase = i_in_data.phase;
                    n_last  = IDX_W'(cnt_c - 7'd1);
                    n_addr  = '0;
                    n_state = S_SRCH;
                end
            end
            S_SRCH: begin
                // one read issued per cycle; its data comes back the cycle after, tagged by r_didx
                n_addr   = r_addr + IDX_W'(1);
                n_didx   = r_addr;
                n_rd_vld = 1'b1;
                if (r_rd_vld) begin
                    if (r_didx == '0) begin
                        n_first = rd_data;
                        n_prev  = rd_data;
                    end else if (hit) begin
                        n_lo     = r_prev;
                        n_hi     = rd_data;
                        n_seg    = r_didx - IDX_W'(1);
                        n_rd_vld = 1'b0;
                        n_state  = S_SETUP;
                    end else if (r_didx == r_last) begin
                        // no segment: extrapolate from first and last
                        n_lo     = r_first;
                        n_hi     = rd_data;
                        n_seg    = '0;
                        n_rd_vld = 1'b0;
                        n_state  = S_SETUP;
                    end else begin
                        n_prev = rd_data;
                    end
                end
            end
            S_SETUP: begin
                n_span = span17[POS_W-1:0];
                n_dneg = d17[POS_W];
                n_dv   = dv17;
                n_quo  = {dmag, 16'd0};
                n_rem  = '0;
                n_cnt  = DIV_LAST;
                if ((span17 <= bci_pkg::SPAN_MIN) || (r_lo.shape == bci_pkg::SHAPE_STEP)) begin
                    // flat: low value passes through FIN unchanged
                    n_acc   = '0;
                    n_step  = M_LIN;
                    n_state = S_FIN;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                // restoring divide, one quotient bit per cycle
                opa   = ACC_W'({r_rem, r_quo[bci_pkg::DIV_STEPS-1]});
                opb   = ~ACC_W'(r_span);
                cin   = 1'b1;
                n_quo = {r_quo[bci_pkg::DIV_STEPS-2:0], ~sum[ACC_W-1]};
                if (!sum[ACC_W-1]) begin
                    n_rem = sum[POS_W-1:0];
                end else begin
                    n_rem = {r_rem[POS_W-2:0], r_quo[bci_pkg::DIV_STEPS-1]};
                end
                n_cnt = r_cnt - 5'd1;
                if (r_cnt == '0) begin
                    n_state = S_LOC;
                end
            end
            S_LOC: begin
                // floor for a negative offset: -q, one less on a remainder
                opa     = r_dneg ? ~ACC_W'(r_quo) : ACC_W'(r_quo);
                cin     = r_dneg && (r_rem == '0);
                n_local = sum[LOC_W-1:0];
                n_state = S_PREP;
            end
            S_PREP: begin
                n_acc   = '0;
                n_mcand = ACC_W'(r_local);
                n_state = S_MUL;
                if (r_lo.shape == bci_pkg::SHAPE_HERMITE) begin
                    n_mplier = loc_mag;
                    n_neg    = r_local[LOC_W-1];
                    n_step   = M_SQ;
                    n_cnt    = MUL_LOC_LAST;
                end else begin
                    n_mplier = LOC_W'(dv_mag);
                    n_neg    = r_dv[VAL_W];
                    n_step   = M_LIN;
                    n_cnt    = MUL_DV_LAST;
                end
            end
            S_MUL: begin
                // shift-add over the multiplier magnitude, LSB first
                opa      = r_acc;
                opb      = r_mplier[0] ? r_mcand : '0;
                n_acc    = sum;
                n_mcand  = r_mcand <<< 1;
                n_mplier = r_mplier >> 1;
                n_cnt    = r_cnt - 5'd1;
                if (r_cnt == '0) begin
                    n_state = S_NEG;
                end
            end
            S_NEG: begin
                opb = r_neg ? ~r_acc : r_acc;
                cin = r_neg;
                case (r_step)
                    M_SQ: begin
                        n_t2     = sum >>> 16;
                        n_mcand  = sum >>> 16;
                        n_acc    = '0;
                        n_mplier = loc_mag;
                        n_neg    = r_local[LOC_W-1];
                        n_cnt    = MUL_LOC_LAST;
                        n_step   = M_CUBE;
                        n_state  = S_MUL;
                    end
                    M_CUBE: begin
                        n_acc   = sum >>> 16;  // t3
                        n_state = S_S1;
                    end
                    default: begin
                        n_acc   = sum;
                        n_state = S_RND;
                    end
                endcase
            end
            S_S1: begin
                opa     = r_t2 <<< 1;
                opb     = r_t2;
                n_mcand = sum;                 // 3*t2
                n_state = S_S2;
            end
            S_S2: begin
                opa     = r_mcand;
                opb     = ~(r_acc <<< 1);
                cin     = 1'b1;
                n_mcand = sum;                 // 3*t2 - 2*t3
                n_state = S_S3;
            end
            S_S3: begin
                opa      = r_mcand;
                opb      = ACC_W'(r_local);
                n_mcand  = sum;                // S = 2p in Q16
                n_acc    = '0;
                n_mplier = LOC_W'(dv_mag);
                n_neg    = r_dv[VAL_W];
                n_cnt    = MUL_DV_LAST;
                n_step   = M_DVS;
                n_state  = S_MUL;
            end
            S_RND: begin
                opa     = r_acc;
                opb     = (r_step == M_LIN) ? ACC_W'(32768) : ACC_W'(65536);
                n_acc   = sum;
                n_state = S_FIN;
            end
            S_FIN: begin
                opa = (r_step == M_LIN) ? (r_acc >>> 16) : (r_acc >>> 17);
                opb = ACC_W'(r_lo.value);
                if (!r_out_vld || i_out_ready) begin
                    n_out.curve_value   = sat;
                    n_out.segment_index = r_seg;
                    n_out_vld           = 1'b1;
                    n_state             = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= bci_pkg::COUNT_RESET;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_rd_vld  <= n_rd_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_phase  <= n_phase;
        r_last   <= n_last;
        r_addr   <= n_addr;
        r_didx   <= n_didx;
        r_first  <= n_first;
        r_prev   <= n_prev;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_seg    <= n_seg;
        r_span   <= n_span;
        r_dneg   <= n_dneg;
        r_dv     <= n_dv;
        r_rem    <= n_rem;
        r_quo    <= n_quo;
        r_local  <= n_local;
        r_acc    <= n_acc;
        r_mcand  <= n_mcand;
        r_t2     <= n_t2;
        r_mplier <= n_mplier;
        r_cnt    <= n_cnt;
        r_neg    <= n_neg;
        r_step   <= n_step;
        r_out    <= n_out;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

FILE: rtl/core/bci_checker.sv
// ----------------------------------------------------------------------------
// bci_checker: port-level checks for the breakpoint curve interpolator
// Watches the word channels over time; bound to the top level.
// ----------------------------------------------------------------------------
module bci_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input bci_pkg::t_in_word   i_in_data,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input bci_pkg::t_out_word  o_out_data
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result word changed while stalled");

    // low index is at most count-2, count at most 64
    a_seg_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.segment_index <= 6'd62))
        else $error("segment index out of range");

    // an evaluate word keeps the sequencer busy past the next edge
    a_eval_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_in_data.operation == bci_pkg::OP_EVAL)
        |=> !o_in_ready)
        else $error("ready after evaluate word");

    // a table write leaves the input ready for the next word
    a_write_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_in_data.operation == bci_pkg::OP_WRITE)
        |=> o_in_ready)
        else $error("not ready after write word");

endmodule

bind breakpoint_curve_interpolator bci_checker u_bci_checker (.*);
